// ----- src/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Shared constants, command and status types for the SHA-1 core.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    // Initial chaining value.
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] IV_E = 32'hC3D2E1F0;

    // Round constants, one per group of twenty rounds.
    localparam logic [31:0] RKEY_0 = 32'h5A827999;
    localparam logic [31:0] RKEY_1 = 32'h6ED9EBA1;
    localparam logic [31:0] RKEY_2 = 32'h8F1BBCDC;
    localparam logic [31:0] RKEY_3 = 32'hCA62C1D6;

    // Padding constants.
    localparam logic [7:0] PAD_MARK        = 8'h80;
    localparam int         LAST_SHORT_FILL = 55;
    localparam logic [5:0] LEN_START       = 6'(LAST_SHORT_FILL + 1);

    localparam int         ROUNDS     = 80;
    localparam logic [6:0] ROUND_LAST = 7'(ROUNDS - 1);

    // Source of the byte shifted into the message block.
    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_MARK,
        SRC_ZERO,
        SRC_LENGTH
    } byte_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      shift_en;
        byte_src_t byte_src;
        logic      count_en;
        logic      load_work;
        logic      round_en;
        logic      update_hash;
        logic      emit;
    } sha1md_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic fill_len_start;
        logic round_last;
        logic out_free;
    } sha1md_status_t;

    // Round constant for a given round number.
    function automatic logic [31:0] round_key(input logic [6:0] round);
        logic [31:0] key;
        if (round < 7'd20)
        begin
            key = RKEY_0;
        end
        else if (round < 7'd40)
        begin
            key = RKEY_1;
        end
        else if (round < 7'd60)
        begin
            key = RKEY_2;
        end
        else
        begin
            key = RKEY_3;
        end
        return key;
    endfunction

    // Round logic function for a given round number.
    function automatic logic [31:0] round_func(input logic [6:0] round,
                                               input logic [31:0] b,
                                               input logic [31:0] c,
                                               input logic [31:0] d);
        logic [31:0] f;
        if (round < 7'd20)
        begin
            f = (b & c) | (~b & d);
        end
        else if (round >= 7'd40 && round < 7'd60)
        begin
            f = (b & c) | (b & d) | (c & d);
        end
        else
        begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// ----- src/sha1md_in_if.sv -----
// ----------------------------------------------------------------------------
// SHA-1 input channel
// Valid/ready channel carrying one message byte and its flags per item.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message,
                    input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message,
                    output ready);
endinterface

// ----- src/sha1md_out_if.sv -----
// ----------------------------------------------------------------------------
// SHA-1 output channel
// Valid/ready channel carrying one 160-bit digest per item.
// ----------------------------------------------------------------------------
interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word_a;
    logic [31:0] digest_word_b;
    logic [31:0] digest_word_c;
    logic [31:0] digest_word_d;
    logic [31:0] digest_word_e;

    modport source (output valid, digest_word_a, digest_word_b, digest_word_c,
                    digest_word_d, digest_word_e, input ready);
    modport sink   (input valid, digest_word_a, digest_word_b, digest_word_c,
                    digest_word_d, digest_word_e, output ready);
endinterface

// ----- src/sha1_message_digest_core.sv -----
// ----------------------------------------------------------------------------
// SHA-1 message digest core
// Streaming SHA-1: one message byte per input item, one digest per message.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one item per cycle while the core is idle. An item
// may carry a message byte (byte_present) and may close the message
// (end_of_message); an item with neither flag is simply consumed.
// A byte that completes a 64-byte block starts a compression: the core loads
// the working registers, runs 80 rounds on the single shared round unit, and
// updates the chaining value.
// On an end item the core appends the padding and the length byte by byte
// (at most 72 bytes over two blocks) and compresses one or two final blocks
// before it emits the digest.
// The digest is held in an output register; a stalled receiver lets the core
// take the next message's bytes, and it only waits when a second digest is
// ready before the first has been taken.
// Reset returns the chaining value to its initial value and clears the
// counters and the output valid flag.
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
    input  logic         clk,
    input  logic         rst_n,
    sha1md_in_if.sink    in_ch,
    sha1md_out_if.source out_ch
);
    import sha1md_pkg::*;

    sha1md_cmd_t    cmd;
    sha1md_status_t status;

    // Sequencer.
    sha1md_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .byte_present   (in_ch.byte_present),
        .end_of_message (in_ch.end_of_message),
        .status         (status),
        .cmd            (cmd)
    );

    // Block buffer, rounds and output register.
    sha1md_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (in_ch.data_byte),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .digest_word_a (out_ch.digest_word_a),
        .digest_word_b (out_ch.digest_word_b),
        .digest_word_c (out_ch.digest_word_c),
        .digest_word_d (out_ch.digest_word_d),
        .digest_word_e (out_ch.digest_word_e)
    );

endmodule

// ----- src/sha1md_datapath.sv -----
// ----------------------------------------------------------------------------
// SHA-1 datapath
// Message block shift line, length and fill counters, round registers,
// chaining value and the output register.
// ----------------------------------------------------------------------------
module sha1md_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               data_byte,
    input  sha1md_pkg::sha1md_cmd_t  cmd,
    output sha1md_pkg::sha1md_status_t status,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic [31:0]              digest_word_a,
    output logic [31:0]              digest_word_b,
    output logic [31:0]              digest_word_c,
    output logic [31:0]              digest_word_d,
    output logic [31:0]              digest_word_e
);
    import sha1md_pkg::*;

    logic [511:0] msg_reg, msg_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [6:0]   round_reg, round_next;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  a_next, b_next, c_next, d_next, e_next;
    logic [31:0]  ha_reg, hb_reg, hc_reg, hd_reg, he_reg;
    logic [31:0]  ha_next, hb_next, hc_next, hd_next, he_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  oa_reg, ob_reg, oc_reg, od_reg, oe_reg;

    logic [7:0]   shift_byte;
    logic [7:0]   len_byte;
    logic [2:0]   len_idx;
    logic [31:0]  w0, w2, w8, w13, w_mix, w_new;
    logic [31:0]  temp;

    // Length byte, most significant first, selected by the fill position.
    assign len_idx  = fill_reg[2:0];
    assign len_byte = 8'(bits_reg >> {3'(3'd7 - len_idx), 3'b000});

    // Byte to shift into the message block.
    always_comb
    begin
        case (cmd.byte_src)
            SRC_INPUT:  shift_byte = data_byte;
            SRC_MARK:   shift_byte = PAD_MARK;
            SRC_ZERO:   shift_byte = 8'h00;
            SRC_LENGTH: shift_byte = len_byte;
            default:    shift_byte = 8'h00;
        endcase
    end

    // Schedule words taken from the sixteen-word window.
    assign w0    = msg_reg[511:480];
    assign w2    = msg_reg[447:416];
    assign w8    = msg_reg[255:224];
    assign w13   = msg_reg[95:64];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[30:0], w_mix[31]};

    // One compression round.
    assign temp = {a_reg[26:0], a_reg[31:27]} + round_func(round_reg, b_reg, c_reg, d_reg)
                  + e_reg + w0 + round_key(round_reg);

    // Message window: bytes shift in during filling, words during rounds.
    always_comb
    begin
        msg_next = msg_reg;
        if (cmd.shift_en)
        begin
            msg_next = {msg_reg[503:0], shift_byte};
        end
        else if (cmd.round_en)
        begin
            msg_next = {msg_reg[479:0], w_new};
        end
    end

    // Fill and bit counters.
    always_comb
    begin
        fill_next = fill_reg;
        bits_next = bits_reg;
        if (cmd.shift_en)
        begin
            fill_next = fill_reg + 6'd1;
        end
        if (cmd.count_en)
        begin
            bits_next = bits_reg + 64'd8;
        end
        if (cmd.emit)
        begin
            fill_next = 6'd0;
            bits_next = 64'd0;
        end
    end

    // Working variables and round counter.
    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        round_next = round_reg;
        if (cmd.load_work)
        begin
            a_next     = ha_reg;
            b_next     = hb_reg;
            c_next     = hc_reg;
            d_next     = hd_reg;
            e_next     = he_reg;
            round_next = 7'd0;
        end
        else if (cmd.round_en)
        begin
            a_next     = temp;
            b_next     = a_reg;
            c_next     = {b_reg[1:0], b_reg[31:2]};
            d_next     = c_reg;
            e_next     = d_reg;
            round_next = round_reg + 7'd1;
        end
    end

    // Chaining value: add the block result, or restart after a digest.
    always_comb
    begin
        ha_next = ha_reg;
        hb_next = hb_reg;
        hc_next = hc_reg;
        hd_next = hd_reg;
        he_next = he_reg;
        if (cmd.update_hash)
        begin
            ha_next = ha_reg + a_reg;
            hb_next = hb_reg + b_reg;
            hc_next = hc_reg + c_reg;
            hd_next = hd_reg + d_reg;
            he_next = he_reg + e_reg;
        end
        else if (cmd.emit)
        begin
            ha_next = IV_A;
            hb_next = IV_B;
            hc_next = IV_C;
            hd_next = IV_D;
            he_next = IV_E;
        end
    end

    // Output register handshake.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 6'd0;
            bits_reg      <= 64'd0;
            round_reg     <= 7'd0;
            ha_reg        <= IV_A;
            hb_reg        <= IV_B;
            hc_reg        <= IV_C;
            hd_reg        <= IV_D;
            he_reg        <= IV_E;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            round_reg     <= round_next;
            ha_reg        <= ha_next;
            hb_reg        <= hb_next;
            hc_reg        <= hc_next;
            hd_reg        <= hd_next;
            he_reg        <= he_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        msg_reg <= msg_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        if (cmd.emit)
        begin
            oa_reg <= ha_reg;
            ob_reg <= hb_reg;
            oc_reg <= hc_reg;
            od_reg <= hd_reg;
            oe_reg <= he_reg;
        end
    end

    // Status back to the controller.
    assign status.fill_last      = (fill_reg == 6'd63);
    assign status.fill_len_start = (fill_reg == LEN_START);
    assign status.round_last     = (round_reg == ROUND_LAST);
    assign status.out_free       = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign digest_word_a = oa_reg;
    assign digest_word_b = ob_reg;
    assign digest_word_c = oc_reg;
    assign digest_word_d = od_reg;
    assign digest_word_e = oe_reg;

endmodule

// ----- src/sha1md_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-1 controller
// Sequences byte intake, padding, length append, compression and output.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       byte_present,
    input  logic                       end_of_message,
    input  sha1md_pkg::sha1md_status_t status,
    output sha1md_pkg::sha1md_cmd_t    cmd
);
    import sha1md_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b00000001,
        ST_PAD_MARK = 8'b00000010,
        ST_PAD_ZERO = 8'b00000100,
        ST_LENGTH   = 8'b00001000,
        ST_LOAD     = 8'b00010000,
        ST_ROUND    = 8'b00100000,
        ST_UPDATE   = 8'b01000000,
        ST_EMIT     = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    state_t resume_reg, resume_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        resume_next = resume_reg;
        cmd         = '0;
        cmd.byte_src = SRC_INPUT;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present)
                    begin
                        cmd.shift_en = 1'b1;
                        cmd.count_en = 1'b1;
                    end
                    if (byte_present && status.fill_last)
                    begin
                        state_next  = ST_LOAD;
                        resume_next = end_of_message ? ST_PAD_MARK : ST_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = SRC_MARK;
                if (status.fill_last)
                begin
                    state_next  = ST_LOAD;
                    resume_next = ST_PAD_ZERO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (status.fill_len_start)
                begin
                    state_next = ST_LENGTH;
                end
                else
                begin
                    cmd.shift_en = 1'b1;
                    cmd.byte_src = SRC_ZERO;
                    if (status.fill_last)
                    begin
                        state_next  = ST_LOAD;
                        resume_next = ST_PAD_ZERO;
                    end
                end
            end
            ST_LENGTH:
            begin
                cmd.shift_en = 1'b1;
                cmd.byte_src = SRC_LENGTH;
                if (status.fill_last)
                begin
                    state_next  = ST_LOAD;
                    resume_next = ST_EMIT;
                end
            end
            ST_LOAD:
            begin
                cmd.load_work = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update_hash = 1'b1;
                state_next      = resume_reg;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            resume_reg <= ST_IDLE;
        end
        else
        begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
        end
    end

endmodule
